// File: hdl/mlq_pkg.sv
// Shared constants, types and codes of the multi-level linked queue manager.
`timescale 1ns / 1ps

package mlq_pkg;

    // Pool size and number of levels; the request fields cover exactly these ranges.
    localparam int QUEUE_LEVELS = 4;
    localparam int ENTRY_COUNT  = 64;
    localparam int NODE_COUNT   = ENTRY_COUNT + QUEUE_LEVELS;

    localparam int REQ_W    = 2;
    localparam int LEVEL_W  = 2;
    localparam int ID_W     = 6;
    localparam int STATUS_W = 2;
    localparam int NODE_W   = $clog2(NODE_COUNT);

    typedef logic [NODE_W-1:0] node_t;

    localparam logic [REQ_W-1:0] REQ_PUSH_TAIL = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_HEAD = 2'd1;
    localparam logic [REQ_W-1:0] REQ_POP_HEAD  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_REMOVE    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_QUEUED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ALREADY    = 2'd3;

    // Sentinel nodes follow the entries in the link memories.
    function automatic node_t sentinel_of(input logic [LEVEL_W-1:0] lvl);
        return node_t'(ENTRY_COUNT) + node_t'(lvl);
    endfunction

endpackage

// File: hdl/multi_level_linked_queue_manager.sv
// Top level: per-level doubly linked FIFOs kept in two link memories.
`timescale 1ns / 1ps

// Usage: a request word (req_type, level, entry_id) enters on the req channel
// and exactly one response word (status, popped_id) leaves on the rsp channel.
// A request is accepted when req_valid is high and req_stall is low; the same
// rule holds for the response with rsp_valid and rsp_stall.
// One request is handled at a time. The forward and backward link memories
// each have one write port and a registered read, so the sequencer walks
// through dependent read and write steps: a push goes through PUSH1, PUSH2
// and RESP, a pop of a non-empty level through POP1, UNLINK and RESP, a
// remove through UNLINK and RESP, a pop of an empty level through POP1 and
// RESP, and a refused push or a remove of an unqueued entry right to RESP.
// req_stall stays high until the response is loaded.
// A finished response sits in an output register; the next request is taken
// as soon as that response is loaded, even if the receiver still stalls it.
// If the receiver stalls and a second response is ready, the block waits.
// Reset empties every queue at once: per-node valid bits make an unwritten
// link read as pointing to its own node, and all queued flags are cleared.
module multi_level_linked_queue_manager
    import mlq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic [REQ_W-1:0]    req_type,
    input  logic [LEVEL_W-1:0]  level,
    input  logic [ID_W-1:0]     entry_id,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [STATUS_W-1:0] status,
    output logic [ID_W-1:0]     popped_id
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PUSH1  = 3'd1;
    localparam logic [2:0] S_PUSH2  = 3'd2;
    localparam logic [2:0] S_POP1   = 3'd3;
    localparam logic [2:0] S_UNLINK = 3'd4;
    localparam logic [2:0] S_RESP   = 3'd5;

    node_t next_mem [NODE_COUNT];
    node_t prev_mem [NODE_COUNT];

    logic [2:0]             state_reg, state_next;
    logic [NODE_COUNT-1:0]  next_vld_reg, prev_vld_reg;
    logic [NODE_COUNT-1:0]  next_vld_next, prev_vld_next;
    logic [ENTRY_COUNT-1:0] queued_reg;
    logic                   rsp_valid_reg, rsp_valid_next;

    node_t next_q_reg, prev_q_reg;
    node_t next_rd_addr_reg, prev_rd_addr_reg;
    logic  next_rd_vld_reg, prev_rd_vld_reg;
    node_t next_rd_addr, prev_rd_addr;
    node_t next_eff, prev_eff;

    logic  next_wr_en, prev_wr_en;
    node_t next_wr_addr, prev_wr_addr, next_wr_data, prev_wr_data;
    logic  unlink_clr, queued_set;

    logic [REQ_W-1:0]    req_reg, req_next;
    node_t               ent_reg, ent_next;
    node_t               sen_reg, sen_next;
    node_t               victim_reg, victim_next;
    node_t               link_reg, link_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [ID_W-1:0]     res_popped_reg, res_popped_next;
    logic                rsp_load;
    logic [STATUS_W-1:0] status_reg;
    logic [ID_W-1:0]     popped_id_reg;

    // A node whose link was never written, or was reset by an unlink, points to itself.
    assign next_eff = next_rd_vld_reg ? next_q_reg : next_rd_addr_reg;
    assign prev_eff = prev_rd_vld_reg ? prev_q_reg : prev_rd_addr_reg;

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        ent_next        = ent_reg;
        sen_next        = sen_reg;
        victim_next     = victim_reg;
        link_next       = link_reg;
        res_status_next = res_status_reg;
        res_popped_next = res_popped_reg;
        next_rd_addr    = '0;
        prev_rd_addr    = '0;
        next_wr_en      = 1'b0;
        prev_wr_en      = 1'b0;
        next_wr_addr    = '0;
        prev_wr_addr    = '0;
        next_wr_data    = '0;
        prev_wr_data    = '0;
        unlink_clr      = 1'b0;
        queued_set      = 1'b0;
        rsp_load        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next        = req_type;
                    ent_next        = node_t'(entry_id);
                    sen_next        = sentinel_of(level);
                    res_status_next = ST_DONE;
                    res_popped_next = '0;
                    unique case (req_type)
                        REQ_PUSH_TAIL, REQ_PUSH_HEAD:
                        begin
                            if (queued_reg[entry_id])
                            begin
                                res_status_next = ST_ALREADY;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                next_rd_addr = sentinel_of(level);
                                prev_rd_addr = sentinel_of(level);
                                state_next   = S_PUSH1;
                            end
                        end
                        REQ_POP_HEAD:
                        begin
                            next_rd_addr = sentinel_of(level);
                            state_next   = S_POP1;
                        end
                        default:
                        begin
                            if (!queued_reg[entry_id])
                            begin
                                res_status_next = ST_NOT_QUEUED;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                victim_next  = node_t'(entry_id);
                                next_rd_addr = node_t'(entry_id);
                                prev_rd_addr = node_t'(entry_id);
                                state_next   = S_UNLINK;
                            end
                        end
                    endcase
                end
            end
            S_PUSH1:
            begin
                // Link the new entry first; its neighbors are fixed up in the next step.
                next_wr_en   = 1'b1;
                prev_wr_en   = 1'b1;
                next_wr_addr = ent_reg;
                prev_wr_addr = ent_reg;
                if (req_reg == REQ_PUSH_TAIL)
                begin
                    next_wr_data = sen_reg;
                    prev_wr_data = prev_eff;
                    link_next    = prev_eff;
                end
                else
                begin
                    next_wr_data = next_eff;
                    prev_wr_data = sen_reg;
                    link_next    = next_eff;
                end
                state_next = S_PUSH2;
            end
            S_PUSH2:
            begin
                next_wr_en   = 1'b1;
                prev_wr_en   = 1'b1;
                next_wr_data = ent_reg;
                prev_wr_data = ent_reg;
                if (req_reg == REQ_PUSH_TAIL)
                begin
                    next_wr_addr = link_reg;
                    prev_wr_addr = sen_reg;
                end
                else
                begin
                    next_wr_addr = sen_reg;
                    prev_wr_addr = link_reg;
                end
                queued_set = 1'b1;
                state_next = S_RESP;
            end
            S_POP1:
            begin
                if (next_eff == sen_reg || next_eff >= node_t'(ENTRY_COUNT))
                begin
                    res_status_next = ST_EMPTY;
                    state_next      = S_RESP;
                end
                else
                begin
                    victim_next  = next_eff;
                    next_rd_addr = next_eff;
                    prev_rd_addr = next_eff;
                    state_next   = S_UNLINK;
                end
            end
            S_UNLINK:
            begin
                next_wr_en   = 1'b1;
                prev_wr_en   = 1'b1;
                next_wr_addr = prev_eff;
                next_wr_data = next_eff;
                prev_wr_addr = next_eff;
                prev_wr_data = prev_eff;
                unlink_clr   = 1'b1;
                if (req_reg == REQ_POP_HEAD)
                begin
                    res_popped_next = victim_reg[ID_W-1:0];
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg && rsp_stall;
        end
    end

    always_comb
    begin
        next_vld_next = next_vld_reg;
        prev_vld_next = prev_vld_reg;
        if (next_wr_en)
        begin
            next_vld_next[next_wr_addr] = 1'b1;
        end
        if (prev_wr_en)
        begin
            prev_vld_next[prev_wr_addr] = 1'b1;
        end
        if (unlink_clr)
        begin
            next_vld_next[victim_reg] = 1'b0;
            prev_vld_next[victim_reg] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            next_vld_reg  <= '0;
            prev_vld_reg  <= '0;
            queued_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            next_vld_reg  <= next_vld_next;
            prev_vld_reg  <= prev_vld_next;
            if (unlink_clr)
            begin
                queued_reg[victim_reg[ID_W-1:0]] <= 1'b0;
            end
            if (queued_set)
            begin
                queued_reg[ent_reg[ID_W-1:0]] <= 1'b1;
            end
        end
    end

    // Link memories: one write and one registered read per cycle each.
    always_ff @(posedge clk)
    begin
        if (next_wr_en)
        begin
            next_mem[next_wr_addr] <= next_wr_data;
        end
        if (prev_wr_en)
        begin
            prev_mem[prev_wr_addr] <= prev_wr_data;
        end
        next_q_reg <= next_mem[next_rd_addr];
        prev_q_reg <= prev_mem[prev_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        next_rd_addr_reg <= next_rd_addr;
        prev_rd_addr_reg <= prev_rd_addr;
        next_rd_vld_reg  <= next_vld_reg[next_rd_addr];
        prev_rd_vld_reg  <= prev_vld_reg[prev_rd_addr];
        req_reg          <= req_next;
        ent_reg          <= ent_next;
        sen_reg          <= sen_next;
        victim_reg       <= victim_next;
        link_reg         <= link_next;
        res_status_reg   <= res_status_next;
        res_popped_reg   <= res_popped_next;
        if (rsp_load)
        begin
            status_reg    <= res_status_reg;
            popped_id_reg <= res_popped_reg;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign popped_id = popped_id_reg;

`ifndef SYNTHESIS
    // Only a successful pop may report an entry.
    a_popped_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status != ST_DONE) |-> (popped_id == '0))
        else $error("popped_id set on a response that is not done");

    // A push only links an entry that is not in any queue yet.
    a_push_unqueued: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUSH2) |-> !queued_reg[ent_reg[ID_W-1:0]])
        else $error("push links an entry that is already queued");

    // Whatever is unlinked must be a queued entry.
    a_unlink_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UNLINK) |-> (victim_reg < node_t'(ENTRY_COUNT)
            && queued_reg[victim_reg[ID_W-1:0]]))
        else $error("unlink of a node that is not a queued entry");

    // A pending response is never overwritten before the receiver takes it.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |-> !rsp_load)
        else $error("response loaded over a stalled response");
`endif

endmodule
